// ===== hdl/rclfd_pkg.sv =====
package rclfd_pkg;

  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 8;

  // hysteresis counter limits
  localparam logic [3:0] LOSS_TRIP     = 4'd10;
  localparam logic [3:0] RECOVER_CLAMP = 4'd3;

  // register indexes (word address = paddr[3:2])
  typedef enum logic [1:0] {
    REG_FS_MODE      = 2'd0,
    REG_FS_THRESHOLD = 2'd1,
    REG_THR_REVERSED = 2'd2,
    REG_TIMEOUT_MS   = 2'd3
  } reg_idx_t;

  // fs_mode codes; the fourth code acts like FS_MODE_NO_ACTION
  localparam logic [1:0] FS_MODE_OFF       = 2'd0;
  localparam logic [1:0] FS_MODE_ON        = 2'd1;
  localparam logic [1:0] FS_MODE_NO_ACTION = 2'd2;

  typedef enum logic [1:0] {
    NOTICE_NONE = 2'd0,
    NOTICE_ON   = 2'd1,
    NOTICE_OFF  = 2'd2,
    NOTICE_RSVD = 2'd3
  } notice_t;

  localparam logic [1:0]  RST_FS_MODE      = FS_MODE_ON;
  localparam logic [11:0] RST_FS_THRESHOLD = 12'd950;
  localparam logic        RST_THR_REVERSED = 1'b0;
  localparam logic [15:0] RST_TIMEOUT_MS   = 16'd1000;

  typedef struct packed {
    logic [1:0]  fs_mode;
    logic [11:0] fs_threshold;
    logic        throttle_reversed;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic        vtol_hold_mode;
    logic        had_input;
    logic        protocols_enabled;
    logic        flying;
    logic        armed;
    logic [31:0] now_ms;
    logic [11:0] throttle_pwm;
    logic        frame_ok;
  } item_t;

  typedef struct packed {
    notice_t notice;
    logic    failsafe_on;
    logic    throttle_half;
    logic    override_sticks;
  } result_t;

  typedef struct packed {
    logic [3:0] loss_counter;
    logic       failsafe_latched;
  } core_status_t;

endpackage

// ===== hdl/rclfd_cfg.sv =====
module rclfd_cfg
  import rclfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output cfg_t                cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  reg_idx_t   idx;

  assign idx   = reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fs_mode           <= RST_FS_MODE;
      cfg_r.fs_threshold      <= RST_FS_THRESHOLD;
      cfg_r.throttle_reversed <= RST_THR_REVERSED;
      cfg_r.timeout_ms        <= RST_TIMEOUT_MS;
    end else if (wr_en) begin
      unique case (idx)
        REG_FS_MODE:      cfg_r.fs_mode           <= pwdata[1:0];
        REG_FS_THRESHOLD: cfg_r.fs_threshold      <= pwdata[11:0];
        REG_THR_REVERSED: cfg_r.throttle_reversed <= pwdata[0];
        REG_TIMEOUT_MS:   cfg_r.timeout_ms        <= pwdata[15:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FS_MODE:      prdata[1:0]  = cfg_r.fs_mode;
      REG_FS_THRESHOLD: prdata[11:0] = cfg_r.fs_threshold;
      REG_THR_REVERSED: prdata[0]    = cfg_r.throttle_reversed;
      REG_TIMEOUT_MS:   prdata[15:0] = cfg_r.timeout_ms;
      default:          prdata       = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/rclfd_core.sv =====
module rclfd_core
  import rclfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         step,
  input  item_t        item,
  output result_t      res,
  output core_status_t status
);

  logic [11:0] last_throttle_r, last_throttle_nxt;
  logic [31:0] last_valid_time_r, last_valid_time_nxt;
  logic [3:0]  loss_counter_r, loss_counter_nxt;
  logic        latched_r, latched_nxt;

  logic        acceptable;
  logic        loss;
  logic        count_en;
  logic [31:0] elapsed;
  logic [3:0]  dec;
  notice_t     notice;

  always_comb begin
    last_throttle_nxt = item.frame_ok ? item.throttle_pwm : last_throttle_r;

    // threshold test on the held throttle; equal is never acceptable
    if (cfg.fs_mode == FS_MODE_OFF)
      acceptable = 1'b1;
    else if (cfg.throttle_reversed)
      acceptable = last_throttle_nxt < cfg.fs_threshold;
    else
      acceptable = last_throttle_nxt > cfg.fs_threshold;

    last_valid_time_nxt = (item.frame_ok && acceptable) ? item.now_ms : last_valid_time_r;
    elapsed = item.now_ms - last_valid_time_nxt;
    loss    = !acceptable || (elapsed > {16'd0, cfg.timeout_ms});

    // counting held off when not in full mode (unless latched) or at boot
    count_en = !(((cfg.fs_mode != FS_MODE_ON) && !latched_r) ||
                 (!item.armed && !item.flying && item.protocols_enabled &&
                  !item.had_input));

    loss_counter_nxt = loss_counter_r;
    latched_nxt      = latched_r;
    notice           = NOTICE_NONE;
    dec              = loss_counter_r - 4'd1;

    if (count_en) begin
      if (loss) begin
        if (loss_counter_r < LOSS_TRIP) begin
          loss_counter_nxt = loss_counter_r + 4'd1;
          if (loss_counter_r + 4'd1 == LOSS_TRIP) begin
            notice      = NOTICE_ON;
            latched_nxt = 1'b1;
          end
        end else begin
          loss_counter_nxt = LOSS_TRIP;
        end
      end else if (loss_counter_r != 4'd0) begin
        loss_counter_nxt = (dec > RECOVER_CLAMP) ? RECOVER_CLAMP : dec;
        if (loss_counter_nxt == 4'd1)
          notice = NOTICE_OFF;
        else if (loss_counter_nxt == 4'd0)
          latched_nxt = 1'b0;
      end
    end

    res.override_sticks = loss;
    res.throttle_half   = loss && item.vtol_hold_mode;
    res.failsafe_on     = latched_nxt;
    res.notice          = notice;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_throttle_r   <= '0;
      last_valid_time_r <= '0;
      loss_counter_r    <= '0;
      latched_r         <= 1'b0;
    end else if (step) begin
      last_throttle_r   <= last_throttle_nxt;
      last_valid_time_r <= last_valid_time_nxt;
      loss_counter_r    <= loss_counter_nxt;
      latched_r         <= latched_nxt;
    end
  end

  assign status.loss_counter     = loss_counter_r;
  assign status.failsafe_latched = latched_r;

endmodule

// ===== hdl/rc_link_failsafe_detector_unit.sv =====
// Receiver link failsafe detector.
// Throughput: one word per cycle while out_tready is high; each word passes the
//   input register, then the result register, each holding one word, and the
//   detector state updates as a word moves between them.
// Reset (rst_n low, synchronous): both stages empty, throttle/time/counter/flag
//   cleared, registers back to fs_mode 1, threshold 950, not reversed, timeout 1000.
module rc_link_failsafe_detector_unit
  import rclfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // [0] frame_ok, [12:1] throttle_pwm, [44:13] now_ms, [45] armed, [46] flying,
  // [47] protocols_enabled, [48] had_input, [49] vtol_hold_mode, [55:50] zero
  input  logic [InDataW-1:0]  in_tdata,
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] override_sticks, [1] throttle_half, [2] failsafe_on, [4:3] notice,
  // [7:5] zero
  output logic [OutDataW-1:0] out_tdata,
  // configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t         cfg;
  item_t        item_r;
  logic         in_valid_r;
  result_t      res_r;
  result_t      res;
  logic         out_valid_r;
  logic         advance;
  core_status_t status;

  assign cfg_pready = 1'b1;

  rclfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // A word in the input register moves on whenever the result register is free
  // or being emptied this cycle; the detector state steps with it.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[49:0]);
    end
  end

  rclfd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (advance),
    .item   (item_r),
    .res    (res),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r};

`ifndef NO_ASSERTIONS
  // hysteresis counter never runs past the trip level
  a_counter_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    status.loss_counter <= LOSS_TRIP)
    else $error("loss counter above trip level");

  // the flag is only ever held with a non-zero counter
  a_latch_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    status.failsafe_latched |-> (status.loss_counter != 4'd0))
    else $error("failsafe latched with zero counter");

  // an on notice always comes with the flag raised in the same word
  a_on_notice_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_r.notice == NOTICE_ON)) |-> res_r.failsafe_on)
    else $error("on notice without failsafe flag");

  // a stalled result word is never overwritten by the next item
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !advance)
    else $error("result register overrun");
`endif

endmodule
